// File: rtl/core/fixed_string_line_filter_assert.svh
`ifndef FIXED_STRING_LINE_FILTER_ASSERT_SVH
`define FIXED_STRING_LINE_FILTER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FSLF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define FSLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fslf_pkg.sv
package fslf_pkg;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  // Configuration register indexes (byte address divided by eight).
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_LENGTH  = 2'd1;
  localparam logic [1:0] REG_COLOR   = 2'd2;

  // Control part of one flush job handed from the front to the back.
  typedef struct packed {
    logic is_line;    // a stored line is emitted, else a single status item
    logic ending;     // job comes from an end command
    logic any_match;  // status reported with the final item
    logic truncated;  // line overflowed the line store
  } fslf_job_t;

endpackage

// File: rtl/core/fslf_queue.sv
module fslf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/fslf_front.sv
module fslf_front #(
  parameter int MAX_PATTERN = 8,
  parameter int LINE_BYTES  = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [7:0]                        in_data_byte,
  input  logic [63:0]                       pattern_bytes,
  input  logic [3:0]                        pattern_length,
  input  logic                              q_full,
  input  logic                              drained,
  output logic                              push,
  output fslf_pkg::fslf_job_t               push_ctrl,
  output logic [$clog2(LINE_BYTES+1)-1:0]   push_length,
  output logic [LINE_BYTES-1:0]             push_marks,
  output logic                              mem_we,
  output logic [((LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1)-1:0] mem_addr,
  output logic [7:0]                        mem_wdata
);

  import fslf_pkg::*;

  localparam int WW = 8 * MAX_PATTERN;
  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  logic [WW-1:0]         win_r, win_nxt, win_shift;
  logic [FW-1:0]         fill_r, fill_nxt, fill_inc;
  logic [LW-1:0]         len_r, len_nxt, new_len;
  logic                  matched_r, matched_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  seen_r, seen_nxt;
  logic [LINE_BYTES-1:0] marks_r, marks_nxt;
  logic [3:0]            eff_len;
  logic                  flush_kind;
  logic                  accept;
  logic                  stored;
  logic                  hit;

  always_comb begin
    if (pattern_length == 4'd0) begin
      eff_len = 4'd1;
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      eff_len = 4'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
  end

  assign flush_kind = in_command || (in_data_byte == NEWLINE_CHAR);
  // Data bytes write the line store, so they wait until the back has read it out.
  assign in_ready   = !q_full && (flush_kind || drained);
  assign accept     = in_valid && in_ready;

  assign win_shift = (win_r << 8) | WW'(in_data_byte);
  assign fill_inc  = (int'(fill_r) == MAX_PATTERN) ? fill_r : fill_r + FW'(1);
  assign stored    = (int'(len_r) < LINE_BYTES);
  assign new_len   = stored ? len_r + LW'(1) : len_r;

  // The pattern's first byte lines up with the oldest byte of the window.
  always_comb begin
    hit = (int'(fill_inc) >= int'(eff_len));
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(eff_len)) begin
        if (pattern_bytes[8*i +: 8] != win_shift[8*(int'(eff_len) - 1 - i) +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign mem_we    = accept && !flush_kind && stored;
  assign mem_addr  = len_r[AW-1:0];
  assign mem_wdata = in_data_byte;

  assign push              = accept && flush_kind && (in_command || matched_r);
  assign push_ctrl.is_line   = matched_r;
  assign push_ctrl.ending    = in_command;
  assign push_ctrl.any_match = in_command && (matched_r || seen_r);
  assign push_ctrl.truncated = matched_r && ovf_r;
  assign push_length       = len_r;
  assign push_marks        = marks_r;

  always_comb begin
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    len_nxt     = len_r;
    matched_nxt = matched_r;
    ovf_nxt     = ovf_r;
    seen_nxt    = seen_r;
    marks_nxt   = marks_r;
    if (accept && flush_kind) begin
      seen_nxt    = seen_r || matched_r;
      win_nxt     = '0;
      fill_nxt    = '0;
      len_nxt     = '0;
      matched_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end else if (accept) begin
      win_nxt     = win_shift;
      fill_nxt    = fill_inc;
      len_nxt     = new_len;
      matched_nxt = matched_r || hit;
      ovf_nxt     = ovf_r || !stored;
      for (int p = 0; p < LINE_BYTES; p++) begin
        if (stored && p == int'(len_r)) begin
          marks_nxt[p] = 1'b0;
        end
        if (hit && stored && p < int'(new_len) &&
            p + int'(eff_len) >= int'(new_len)) begin
          marks_nxt[p] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    marks_r <= marks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      fill_r    <= '0;
      len_r     <= '0;
      matched_r <= 1'b0;
      ovf_r     <= 1'b0;
      seen_r    <= 1'b0;
    end else begin
      win_r     <= win_nxt;
      fill_r    <= fill_nxt;
      len_r     <= len_nxt;
      matched_r <= matched_nxt;
      ovf_r     <= ovf_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

// File: rtl/core/fslf_back.sv
module fslf_back #(
  parameter int LINE_BYTES = 63
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  fslf_pkg::fslf_job_t             q_ctrl,
  input  logic [$clog2(LINE_BYTES+1)-1:0] q_length,
  input  logic [LINE_BYTES-1:0]           q_marks,
  output logic                            pop,
  output logic                            active,
  input  logic                            mem_we,
  input  logic [((LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1)-1:0] mem_addr,
  input  logic [7:0]                      mem_wdata,
  input  logic                            color_enable,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [7:0]                      out_byte,
  output logic                            out_highlight,
  output logic                            out_last,
  output logic                            out_done_res,
  output logic                            out_any_match,
  output logic                            out_truncated
);

  import fslf_pkg::*;

  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  logic [7:0]            store_mem [LINE_BYTES];
  logic [7:0]            rdata_r;
  fslf_job_t             job_r, job_nxt;
  logic [LW-1:0]         job_len_r, job_len_nxt;
  logic [LINE_BYTES-1:0] job_marks_r, job_marks_nxt;
  logic                  active_r, active_nxt;
  logic [LW-1:0]         idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  hl_r, hl_nxt;
  logic                  last_r, last_nxt;
  logic                  done_r, done_nxt;
  logic                  any_r, any_nxt;
  logic                  trunc_r, trunc_nxt;
  logic                  load;

  assign pop    = !active_r && !q_empty;
  assign active = active_r;
  assign load   = !out_valid_r || out_ready;

  always_comb begin
    job_nxt       = job_r;
    job_len_nxt   = job_len_r;
    job_marks_nxt = job_marks_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    byte_nxt      = byte_r;
    hl_nxt        = hl_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    any_nxt       = any_r;
    trunc_nxt     = trunc_r;
    if (pop) begin
      job_nxt       = q_ctrl;
      job_len_nxt   = q_length;
      job_marks_nxt = q_marks;
      active_nxt    = 1'b1;
      idx_nxt       = '0;
    end else if (active_r && load) begin
      out_valid_nxt = 1'b1;
      trunc_nxt     = job_r.truncated;
      if (job_r.is_line && idx_r < job_len_r) begin
        byte_nxt = rdata_r;
        hl_nxt   = job_marks_r[idx_r[AW-1:0]] && color_enable;
        last_nxt = 1'b0;
        done_nxt = 1'b0;
        any_nxt  = 1'b0;
        idx_nxt  = idx_r + LW'(1);
      end else begin
        // Closing newline of a line, or the lone status item of an end command.
        byte_nxt   = job_r.is_line ? NEWLINE_CHAR : 8'd0;
        hl_nxt     = 1'b0;
        last_nxt   = 1'b1;
        done_nxt   = job_r.ending;
        any_nxt    = job_r.any_match;
        active_nxt = 1'b0;
        idx_nxt    = '0;
      end
    end
  end

  // The read address follows the next index, so rdata_r always holds the byte at idx_r.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= store_mem[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    job_len_r   <= job_len_nxt;
    job_marks_r <= job_marks_nxt;
    byte_r      <= byte_nxt;
    hl_r        <= hl_nxt;
    last_r      <= last_nxt;
    done_r      <= done_nxt;
    any_r       <= any_nxt;
    trunc_r     <= trunc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_highlight = hl_r;
  assign out_last      = last_r;
  assign out_done_res  = done_r;
  assign out_any_match = any_r;
  assign out_truncated = trunc_r;

endmodule

// File: rtl/core/fixed_string_line_filter.sv
// Data bytes are accepted one per cycle and produce no item of their own.
// A newline or end command after a matched line of N stored bytes emits N+1 items,
// one per cycle unless out_ready stalls them, from the back's line store read port.
// Data bytes stall while a flush is queued or being emitted; newlines and end commands
// wait only for room in the two-entry job queue. Synchronous active-low reset clears the
// line state, the match history and the queue; the line store itself is not cleared.
module fixed_string_line_filter #(
  parameter int MAX_PATTERN = 8,
  parameter int LINE_BYTES  = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_highlight,
  output logic        out_last,
  output logic        out_done_res,
  output logic        out_any_match,
  output logic        out_truncated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  import fslf_pkg::*;

  localparam int LW = $clog2(LINE_BYTES + 1);
  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int CW = $bits(fslf_job_t);
  localparam int QW = CW + LW + LINE_BYTES;

  logic [63:0]           pattern_r;
  logic [3:0]            length_r;
  logic                  color_r;
  logic                  cfg_wr;
  logic                  q_full, q_empty, q_push, q_pop;
  logic [QW-1:0]         q_wdata, q_rdata;
  fslf_job_t             push_ctrl, pop_ctrl;
  logic [LW-1:0]         push_length, pop_length;
  logic [LINE_BYTES-1:0] push_marks, pop_marks;
  logic                  back_active;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [7:0]            mem_wdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= 4'd1;
      color_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_PATTERN: pattern_r <= pwdata;
        REG_LENGTH:  length_r  <= pwdata[3:0];
        REG_COLOR:   color_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_PATTERN: prdata = pattern_r;
      REG_LENGTH:  prdata = 64'(length_r);
      REG_COLOR:   prdata = 64'(color_r);
      default:     prdata = '0;
    endcase
  end

  fslf_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .LINE_BYTES  (LINE_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .pattern_bytes  (pattern_r),
    .pattern_length (length_r),
    .q_full         (q_full),
    .drained        (q_empty && !back_active),
    .push           (q_push),
    .push_ctrl      (push_ctrl),
    .push_length    (push_length),
    .push_marks     (push_marks),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata)
  );

  assign q_wdata = {push_ctrl, push_length, push_marks};
  assign {pop_ctrl, pop_length, pop_marks} = q_rdata;

  fslf_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  fslf_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctrl        (pop_ctrl),
    .q_length      (pop_length),
    .q_marks       (pop_marks),
    .pop           (q_pop),
    .active        (back_active),
    .mem_we        (mem_we),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .color_enable  (color_r),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_highlight (out_highlight),
    .out_last      (out_last),
    .out_done_res  (out_done_res),
    .out_any_match (out_any_match),
    .out_truncated (out_truncated)
  );

endmodule

// File: rtl/core/fslf_checker.sv
`include "fixed_string_line_filter_assert.svh"

module fslf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_highlight,
  input logic        out_last,
  input logic        out_done_res,
  input logic        out_any_match
);

  // An item that ends the input is always the last one of its command.
  `FSLF_ASSERT(a_done_is_last, clk, rst_n, !out_valid || !out_done_res || out_last, "done item not last")
  // The match status is only reported on the item that ends the input.
  `FSLF_ASSERT(a_any_needs_done, clk, rst_n, !out_valid || !out_any_match || out_done_res, "any_match without done")
  // Closing newlines and status items never carry a highlight.
  `FSLF_ASSERT(a_last_no_hl, clk, rst_n, !out_valid || !out_last || !out_highlight, "highlight on last item")
  // A result that is not taken stays offered.
  `FSLF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind fixed_string_line_filter fslf_checker u_fslf_checker (.*);
